[hw/rtl/ekvt_pkg.sv]
package ekvt_pkg;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [7:0] ChPipe  = 8'h7C;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChEq    = 8'h3D;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChS     = 8'h73;
  localparam logic [7:0] ChP     = 8'h70;
  localparam logic [7:0] ChA     = 8'h61;
  localparam logic [7:0] ChB     = 8'h62;
  localparam logic [7:0] ChF     = 8'h66;
  localparam logic [7:0] ChN     = 8'h6E;
  localparam logic [7:0] ChR     = 8'h72;
  localparam logic [7:0] ChT     = 8'h74;
  localparam logic [7:0] ChV     = 8'h76;

  typedef enum logic [2:0] {
    KIND_KEY        = 3'd0,
    KIND_VALUE      = 3'd1,
    KIND_PAIR_END   = 3'd2,
    KIND_RECORD_END = 3'd3,
    KIND_LINE_END   = 3'd4
  } kind_e;

  // Tokens caused by one item, in emission order: data byte, pair end,
  // record end, line end.
  typedef struct packed {
    logic       dat_v;
    kind_e      dat_kind;
    logic [7:0] dat_byte;
    logic       pe;
    logic       re;
    logic       le;
  } bundle_t;

  function automatic logic [7:0] decode_escape(input logic [7:0] b);
    logic [7:0] r;
    case (b)
      ChBslash: r = ChBslash;
      ChSlash:  r = ChSlash;
      ChS:      r = ChSpace;
      ChP:      r = ChPipe;
      ChA:      r = 8'd7;
      ChB:      r = 8'd8;
      ChF:      r = 8'd12;
      ChN:      r = 8'd10;
      ChR:      r = 8'd13;
      ChT:      r = 8'd9;
      ChV:      r = 8'd11;
      default:  r = ChBslash;
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/escaped_key_value_line_tokenizer.sv]
// Byte-stream tokenizer for key=value reply lines: records split on '|',
// pairs on spaces, value bytes unescaped. One input item is taken per cycle
// while the four-entry token queue has room; results leave the output
// register one per cycle while out_ready_i holds, so an item with n results
// (up to four, when a backslash, pair end, record end and line end fall
// together) holds the back end until all n have left; sustained throughput
// is one item per cycle while items average one result or fewer and
// out_ready_i holds. An item's first result goes through the queue, then the output register.
module escaped_key_value_line_tokenizer import ekvt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_line_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] out_kind_o,
  output logic [7:0] out_byte_o,
  output logic       last_o
);

  bundle_t fr_bundle, head;
  logic    push, full, pop, head_valid, accept;

  assign in_ready_o = !full;
  assign accept = in_valid_i && in_ready_o;

  ekvt_front u_front (
    .clk_i, .rst_ni,
    .accept_i(accept),
    .in_byte_i, .end_of_line_i,
    .bundle_o(fr_bundle),
    .push_o(push)
  );

  ekvt_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(push),
    .push_data_i(fr_bundle),
    .full_o(full),
    .pop_i(pop),
    .head_valid_o(head_valid),
    .head_o(head)
  );

  ekvt_back u_back (
    .clk_i, .rst_ni,
    .head_valid_i(head_valid),
    .head_i(head),
    .pop_o(pop),
    .out_valid_o, .out_ready_i,
    .out_kind_o, .out_byte_o, .last_o
  );

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_kind_o <= KIND_LINE_END)
    else $error("result kind out of range");

  a_ctrl_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_kind_o != KIND_KEY && out_kind_o != KIND_VALUE
      |-> out_byte_o == 8'd0)
    else $error("control token carries a byte");

  a_line_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_kind_o == KIND_LINE_END |-> last_o)
    else $error("line end not last of its item");

  a_pop_needs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head_valid)
    else $error("queue popped while empty");

endmodule

[hw/rtl/ekvt_front.sv]
module ekvt_front import ekvt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_line_i,
  output bundle_t    bundle_o,
  output logic       push_o
);

  logic rec_q, rec_d, pair_q, pair_d, val_q, val_d, esc_q, esc_d;
  bundle_t b;

  always_comb begin
    rec_d = rec_q;
    pair_d = pair_q;
    val_d = val_q;
    esc_d = esc_q;
    b.dat_v = 1'b0;
    b.dat_kind = KIND_VALUE;
    b.dat_byte = ChBslash;
    b.pe = 1'b0;
    b.re = 1'b0;
    b.le = 1'b0;
    if (end_of_line_i || in_byte_i == ChPipe) begin
      // flush a dangling backslash, then close pair and record
      b.dat_v = esc_q;
      b.pe = pair_q;
      b.re = rec_q;
      b.le = end_of_line_i;
      rec_d = 1'b0;
      pair_d = 1'b0;
      val_d = 1'b0;
      esc_d = 1'b0;
    end else if (in_byte_i == ChSpace) begin
      b.dat_v = esc_q;
      b.pe = pair_q;
      rec_d = 1'b1;
      pair_d = 1'b0;
      val_d = 1'b0;
      esc_d = 1'b0;
    end else begin
      rec_d = 1'b1;
      pair_d = 1'b1;
      if (!val_q) begin
        if (in_byte_i == ChEq) begin
          val_d = 1'b1;
        end else begin
          b.dat_v = 1'b1;
          b.dat_kind = KIND_KEY;
          b.dat_byte = in_byte_i;
        end
      end else if (esc_q) begin
        esc_d = 1'b0;
        b.dat_v = 1'b1;
        b.dat_byte = decode_escape(in_byte_i);
      end else if (in_byte_i == ChBslash) begin
        esc_d = 1'b1;
      end else begin
        b.dat_v = 1'b1;
        b.dat_byte = in_byte_i;
      end
    end
  end

  assign bundle_o = b;
  assign push_o = accept_i && (b.dat_v || b.pe || b.re || b.le);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q <= 1'b0;
      pair_q <= 1'b0;
      val_q <= 1'b0;
      esc_q <= 1'b0;
    end else if (accept_i) begin
      rec_q <= rec_d;
      pair_q <= pair_d;
      val_q <= val_d;
      esc_q <= esc_d;
    end
  end

endmodule

[hw/rtl/ekvt_queue.sv]
module ekvt_queue import ekvt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  bundle_t push_data_i,
  output logic    full_o,
  input  logic    pop_i,
  output logic    head_valid_o,
  output bundle_t head_o
);

  bundle_t mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q, cnt_d;

  assign full_o = cnt_q == QCntW'(QDepth);
  assign head_valid_o = cnt_q != '0;
  assign head_o = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    else if (pop_i && !push_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

endmodule

[hw/rtl/ekvt_back.sv]
module ekvt_back import ekvt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       head_valid_i,
  input  bundle_t    head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] out_kind_o,
  output logic [7:0] out_byte_o,
  output logic       last_o
);

  logic [3:0] tok, pend, pick, done_q;
  logic       load, fin;
  logic       valid_q;
  kind_e      kind_q, kind_d;
  logic [7:0] byte_q, byte_d;
  logic       last_q;

  assign tok  = {head_i.le, head_i.re, head_i.pe, head_i.dat_v};
  assign pend = tok & ~done_q;
  assign pick = pend & (~pend + 4'd1);
  assign fin  = (pend & ~pick) == 4'd0;
  assign load = head_valid_i && (!valid_q || out_ready_i);
  assign pop_o = load && fin;

  always_comb begin
    kind_d = KIND_LINE_END;
    byte_d = 8'd0;
    if (pick[0]) begin
      kind_d = head_i.dat_kind;
      byte_d = head_i.dat_byte;
    end else if (pick[1]) begin
      kind_d = KIND_PAIR_END;
    end else if (pick[2]) begin
      kind_d = KIND_RECORD_END;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= kind_d;
      byte_q <= byte_d;
      last_q <= fin;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      done_q <= '0;
    end else begin
      if (load) valid_q <= 1'b1;
      else if (out_ready_i) valid_q <= 1'b0;
      // advance through the head item's tokens, clear once it is popped
      if (load) done_q <= fin ? 4'd0 : (done_q | pick);
    end
  end

  assign out_valid_o = valid_q;
  assign out_kind_o  = kind_q;
  assign out_byte_o  = byte_q;
  assign last_o      = last_q;

endmodule
